/* hw/rtl/nsr_pkg.sv */
package nsr_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_FORM = 2'd2;

    // Register widths and reset values.
    localparam int TOL_W  = 32;
    localparam int ITER_W = 8;

    localparam logic [TOL_W-1:0]  TOL_RESET      = 32'd1;
    localparam logic [ITER_W-1:0] MAX_ITER_RESET = 8'd200;

    // Step form codes.
    localparam logic FORM_SINGLE = 1'b0;
    localparam logic FORM_DOUBLE = 1'b1;

    // Multiplier bits retired per cycle.
    localparam int MUL_DIGIT = 8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_GO,
        S_SQ_WAIT,
        S_CHK,
        S_DIVQ,
        S_DIV2,
        S_MULAX,
        S_DIV3,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/nsr_mul.sv */
module nsr_mul import nsr_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [WIDTH-1:0]   i_mcand,
    input  logic [WIDTH-1:0]   i_mplier,
    output logic               o_done,
    output logic [2*WIDTH-1:0] o_product
);

    localparam int MW = MUL_DIGIT * ((WIDTH + MUL_DIGIT - 1) / MUL_DIGIT);
    localparam int ND = MW / MUL_DIGIT;
    localparam int CW = $clog2(ND + 1);

    logic [2*MW-1:0]          r_p;
    logic [WIDTH-1:0]         r_mcand;
    logic [CW-1:0]            r_cnt;
    logic                     r_busy;
    logic                     r_done;

    logic [WIDTH+MUL_DIGIT-1:0] pp;
    logic [MW+MUL_DIGIT-1:0]    sum;
    logic [2*MW-1:0]            n_p;

    // One multiplier digit per cycle; the low half of r_p holds the digits
    // still to be used and shifts out as the product shifts in.
    assign pp  = (WIDTH+MUL_DIGIT)'(r_mcand) * (WIDTH+MUL_DIGIT)'(r_p[MUL_DIGIT-1:0]);
    assign sum = (MW+MUL_DIGIT)'(r_p[2*MW-1:MW]) + (MW+MUL_DIGIT)'(pp);
    assign n_p = {sum, r_p[MW-1:MUL_DIGIT]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ND);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p     <= {MW'(0), MW'(i_mplier)};
            r_mcand <= i_mcand;
        end else if (r_busy) begin
            r_p <= n_p;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_p[2*WIDTH-1:0];

endmodule

/* hw/rtl/nsr_div.sv */
module nsr_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 65
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_r;
    logic [DEN_W-1:0] r_d;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W+1:0] trial;
    logic             ge;
    logic [DEN_W-1:0] n_r;

    // Restoring division, one quotient bit per cycle. The partial remainder
    // stays below the divisor, so the shifted value fits one extra bit.
    assign trial = {1'b0, r_r, r_q[NUM_W-1]} - {2'b00, r_d};
    assign ge    = !trial[DEN_W+1];
    assign n_r   = ge ? trial[DEN_W-1:0] : {r_r[DEN_W-2:0], r_q[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_busy) begin
            r_q <= {r_q[NUM_W-2:0], ge};
            r_r <= n_r;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* hw/rtl/newton_square_root.sv */
// Channel   Valid       Stall       Word
// -------   ---------   ---------   ----------------------------------------
// input     i_valid     o_stall     i_radicand
// output    o_valid     i_stall     o_root, o_steps_used, o_converged
// config    i_cfg_we    (none)      i_cfg_index, i_cfg_data
//
// Zero and exactly one go straight to the done state and load the output register
// once it is free. Other inputs run one step per iteration: a squaring, a compare and
// a divider pass; the double-step form adds a multiply and a second divide. Reset is
// synchronous and active low and restores the register defaults. The input is stalled
// from acceptance until the result moves to the output register; a stalled output
// holds its word.
module newton_square_root import nsr_pkg::*; #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [VALUE_WIDTH-1:0] i_radicand,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [VALUE_WIDTH-1:0] o_root,
    output logic [ITER_W-1:0]      o_steps_used,
    output logic                   o_converged,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int W  = VALUE_WIDTH;
    localparam int XW = (VALUE_WIDTH > FRAC_BITS) ? VALUE_WIDTH : FRAC_BITS;
    localparam int NW = VALUE_WIDTH + XW;
    localparam int DW = NW + 1;

    localparam logic [W-1:0] VAL_MAX = {W{1'b1}};
    localparam logic [XW:0]  ONE_FX  = (XW+1)'(1) << FRAC_BITS;

    t_state r_state, n_state;

    logic [TOL_W-1:0]  r_tol;
    logic [ITER_W-1:0] r_max_it;
    logic              r_form;

    logic [W-1:0]      r_a;
    logic [W-1:0]      r_x;
    logic [ITER_W-1:0] r_n;
    logic              r_ok;
    logic [NW-1:0]     r_err;
    logic [NW-1:0]     r_s;
    logic [W-1:0]      r_t2;
    logic              r_dz;

    logic              r_out_valid;
    logic [W-1:0]      r_root;
    logic [ITER_W-1:0] r_steps;
    logic              r_conv;

    // Unit handshakes.
    logic              mul_start, mul_done;
    logic [W-1:0]      mul_b;
    logic [2*W-1:0]    mul_product;
    logic              div_start, div_done;
    logic [NW-1:0]     div_num, div_quot;
    logic [DW-1:0]     div_den;

    logic              in_accept;
    logic              out_load;

    // Datapath.
    logic [XW:0]       a_ext;
    logic              special;
    logic [W:0]        a_dbl;
    logic [W-1:0]      init_x;
    logic [NW-1:0]     sq, target, err, s_val;
    logic              tol_met, at_limit;
    logic [NW-1:0]     q_eff;
    logic [NW:0]       single_sum;
    logic [NW-1:0]     single_half;
    logic [W-1:0]      x_single;
    logic [W-1:0]      q_sat;
    logic [W+1:0]      double_sum;
    logic [W-1:0]      x_double;

    nsr_mul #(.WIDTH(W)) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (r_x),
        .i_mplier  (mul_b),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    nsr_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // First guess and special inputs.
    assign a_ext   = (XW+1)'(i_radicand);
    assign special = (a_ext == '0) || (a_ext == ONE_FX);
    assign a_dbl   = {i_radicand, 1'b0};
    assign init_x  = (a_ext > ONE_FX) ? (i_radicand >> 1) :
                     (a_dbl[W] ? VAL_MAX : a_dbl[W-1:0]);

    // Error of the current guess and the double-step denominator.
    assign sq     = NW'(mul_product);
    assign target = NW'(r_a) << FRAC_BITS;
    assign err    = (sq >= target) ? (sq - target) : (target - sq);
    assign s_val  = (sq >> FRAC_BITS) + NW'(r_a);

    assign tol_met  = r_err <= NW'(r_tol);
    assign at_limit = r_n >= r_max_it;

    // A quotient by zero saturates to the field maximum.
    assign q_eff       = r_dz ? NW'(VAL_MAX) : div_quot;
    assign single_sum  = (NW+1)'(r_x) + (NW+1)'(q_eff);
    assign single_half = single_sum[NW:1];
    assign x_single    = (|single_half[NW-1:W]) ? VAL_MAX : single_half[W-1:0];

    assign q_sat      = (r_dz || (|div_quot[NW-1:W])) ? VAL_MAX : div_quot[W-1:0];
    assign double_sum = (W+2)'(r_x >> 2) + (W+2)'(r_t2) + (W+2)'(q_sat);
    assign x_double   = (|double_sum[W+1:W]) ? VAL_MAX : double_sum[W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = special ? S_DONE : S_SQ_GO;
                end
            end
            S_SQ_GO: begin
                n_state = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (mul_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (tol_met || at_limit) begin
                    n_state = S_DONE;
                end else if (r_form == FORM_DOUBLE) begin
                    n_state = S_DIV2;
                end else begin
                    n_state = S_DIVQ;
                end
            end
            S_DIVQ: begin
                if (div_done) begin
                    n_state = S_SQ_GO;
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    n_state = S_MULAX;
                end
            end
            S_MULAX: begin
                if (mul_done) begin
                    n_state = S_DIV3;
                end
            end
            S_DIV3: begin
                if (div_done) begin
                    n_state = S_SQ_GO;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_stall   = (r_state != S_IDLE);
        in_accept = i_valid && (r_state == S_IDLE);
        out_load  = (r_state == S_DONE) && (!r_out_valid || !i_stall);
        mul_start = (r_state == S_SQ_GO) || ((r_state == S_DIV2) && div_done);
        mul_b     = (r_state == S_DIV2) ? r_a : r_x;
        div_start = ((r_state == S_CHK) && !tol_met && !at_limit) ||
                    ((r_state == S_MULAX) && mul_done);
        if (r_state == S_MULAX) begin
            div_num = NW'(mul_product);
            div_den = DW'(r_s);
        end else begin
            div_num = target;
            div_den = (r_form == FORM_DOUBLE) ? (DW'(r_x) << 2) : DW'(r_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tol       <= TOL_RESET;
            r_max_it    <= MAX_ITER_RESET;
            r_form      <= FORM_SINGLE;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TOLERANCE: r_tol    <= i_cfg_data[TOL_W-1:0];
                    CFG_MAX_ITER:  r_max_it <= i_cfg_data[ITER_W-1:0];
                    CFG_STEP_FORM: r_form   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a  <= i_radicand;
            r_n  <= '0;
            r_x  <= special ? i_radicand : init_x;
            r_ok <= 1'b1;
        end
        if ((r_state == S_SQ_WAIT) && mul_done) begin
            r_err <= err;
            r_s   <= s_val;
        end
        if (r_state == S_CHK) begin
            r_ok <= tol_met;
        end
        if (div_start) begin
            r_dz <= (div_den == '0);
        end
        if ((r_state == S_DIVQ) && div_done) begin
            r_x <= x_single;
            r_n <= r_n + ITER_W'(1);
        end
        if ((r_state == S_DIV2) && div_done) begin
            r_t2 <= q_sat;
        end
        if ((r_state == S_DIV3) && div_done) begin
            r_x <= x_double;
            r_n <= r_n + ITER_W'(1);
        end
        if (out_load) begin
            r_root  <= r_x;
            r_steps <= r_n;
            r_conv  <= r_ok;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_root       = r_root;
    assign o_steps_used = r_steps;
    assign o_converged  = r_conv;

endmodule

/* dv/tb_newton_square_root.sv */
`timescale 1ns / 100ps

module tb_newton_square_root import nsr_pkg::*;;

    localparam int FB = 16;
    localparam logic [63:0] VAL_MAX = 64'hFFFF_FFFF;
    localparam logic [63:0] ONE_Q = 64'h0001_0000;
    localparam int HOLD_CYCLES = 4000;

    // Special values and exact squares first, then field extremes, then words run with a zero tolerance.
    localparam logic [31:0] DIRECTED [0:15] = '{
        32'h0000_0000, 32'h0001_0000, 32'h0004_0000, 32'h0009_0000,
        32'h0000_0001, 32'h0000_FFFF, 32'h0001_0001, 32'h0001_9000, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
        32'h0100_0000, 32'h0003_0000, 32'h0000_4000
    };

    typedef struct packed {
        logic [31:0]       root;
        logic [ITER_W-1:0] steps;
        logic              conv;
    } t_root_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [31:0]           i_radicand = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [31:0]           o_root;
    logic [ITER_W-1:0]     o_steps_used;
    logic                  o_converged;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic [TOL_W-1:0]  tol_reg = TOL_RESET;
    logic [ITER_W-1:0] max_iter_reg = MAX_ITER_RESET;
    logic              form_reg = FORM_SINGLE;

    logic [31:0] radicand_q[$];
    t_root_word  root_expect_q[$];
    t_root_word  exp_w;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          err_count = 0;
    logic        pressure_go = 1'b0;
    logic        holding = 1'b0;
    longint      cycle_count = 0;
    longint      cycle_limit = 20000;

    newton_square_root uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_radicand   (i_radicand),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_root       (o_root),
        .o_steps_used (o_steps_used),
        .o_converged  (o_converged),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [63:0] clamp_val(input logic [63:0] v);
        return (v > VAL_MAX) ? VAL_MAX : v;
    endfunction

    function automatic logic [63:0] quot_sat(input logic [63:0] n, input logic [63:0] d);
        return (d == 0) ? VAL_MAX : n / d;
    endfunction

    // Distance of x squared from the radicand, both with 2*FB fraction bits.
    function automatic logic [63:0] sq_error(input logic [63:0] x, input logic [63:0] a);
        logic [63:0] sq;
        logic [63:0] target;
        sq = x * x;
        target = a << FB;
        return (sq >= target) ? sq - target : target - sq;
    endfunction

    function automatic t_root_word predict_root(input logic [31:0] rad);
        logic [63:0] a;
        logic [63:0] x;
        logic [63:0] s;
        int unsigned n;
        t_root_word w;
        a = {32'd0, rad};
        n = 0;
        if (a == 0 || a == ONE_Q) begin
            x = a;
            w.conv = 1'b1;
        end else begin
            x = (a > ONE_Q) ? (a >> 1) : clamp_val(a << 1);
            while (sq_error(x, a) > tol_reg && n < max_iter_reg) begin
                if (form_reg == FORM_DOUBLE) begin
                    s = ((x * x) >> FB) + a;
                    x = clamp_val((x >> 2) + clamp_val(quot_sat(a << FB, x << 2))
                                  + clamp_val(quot_sat(a * x, s)));
                end else begin
                    x = clamp_val((x + quot_sat(a << FB, x)) >> 1);
                end
                n++;
            end
            w.conv = (sq_error(x, a) <= tol_reg);
        end
        w.root = x[31:0];
        w.steps = n[ITER_W-1:0];
        return w;
    endfunction

    // Mostly well-formed values of every magnitude, with exact squares and the
    // two pass-through values mixed in.
    function automatic logic [31:0] next_radicand();
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? ONE_Q[31:0] : 32'd0;
            1, 2: begin
                k = $urandom_range(1, 65535);
                return k * k;
            end
            3, 4: return $urandom >> $urandom_range(0, 31);
            5: return $urandom_range(1, 32'h0000_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // Driver: offers queued words, predicts each one at acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                root_expect_q.push_back(predict_root(i_radicand));
            end
            if (!i_valid || !o_stall) begin
                if (radicand_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    i_radicand <= radicand_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_radicand <= $urandom;
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result word against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (root_expect_q.size() == 0) begin
                    $error("unexpected result word: root %h", o_root);
                    err_count++;
                end else begin
                    exp_w = root_expect_q.pop_front();
                    if (o_root !== exp_w.root) begin
                        $error("root: expected %h, got %h", exp_w.root, o_root);
                        err_count++;
                    end
                    if (o_steps_used !== exp_w.steps) begin
                        $error("steps_used: expected %0d, got %0d", exp_w.steps, o_steps_used);
                        err_count++;
                    end
                    if (o_converged !== exp_w.conv) begin
                        $error("converged: expected %b, got %b", exp_w.conv, o_converged);
                        err_count++;
                    end
                end
            end
            i_stall <= holding || ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit) begin
            $display("tb_newton_square_root: errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_TOLERANCE: tol_reg = data;
            CFG_MAX_ITER: max_iter_reg = data[ITER_W-1:0];
            CFG_STEP_FORM: form_reg = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] tol, input logic [7:0] iters,
                             input logic form);
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_MAX_ITER, {24'd0, iters});
        write_reg(CFG_STEP_FORM, {31'd0, form});
    endtask

    // Sets the idle and stall mix, extends the time limit for the queued words and waits
    // until every one of them has come back.
    task automatic settle(input int idle, input int stall);
        gap_pct = idle;
        stall_pct = stall;
        cycle_limit += longint'(radicand_q.size()) * ((longint'(max_iter_reg) + 1) * 640 + 400)
                       + 2000;
        while (radicand_q.size() != 0 || i_valid || root_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_directed(input int first, input int last);
        @(negedge i_clk);
        for (int i = first; i <= last; i++) begin
            radicand_q.push_back(DIRECTED[i]);
        end
        settle(0, 0);
    endtask

    task automatic run_random(input int count, input int idle, input int stall);
        @(negedge i_clk);
        for (int i = 0; i < count; i++) begin
            radicand_q.push_back(next_radicand());
        end
        settle(idle, stall);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults straight out of reset.
        run_directed(0, 3);
        configure(32'h0400_0000, 8'd40, FORM_SINGLE);
        run_directed(4, 12);
        configure(32'h0400_0000, 8'd40, FORM_DOUBLE);
        run_directed(4, 12);
        // A zero tolerance only stops early on an exact square.
        configure(32'h0000_0000, 8'd255, FORM_SINGLE);
        run_directed(13, 15);

        configure($urandom_range(32'h0400_0000, 32'h7FFF_FFFF), 8'($urandom_range(12, 40)),
                  FORM_SINGLE);
        run_random(200, 0, 0);
        configure($urandom_range(32'h0400_0000, 32'h7FFF_FFFF), 8'($urandom_range(12, 40)),
                  FORM_DOUBLE);
        run_random(150, 67, 0);
        configure($urandom_range(32'h0400_0000, 32'h7FFF_FFFF), 8'($urandom_range(12, 40)),
                  FORM_SINGLE);
        run_random(200, 0, 67);
        configure($urandom_range(32'h0400_0000, 32'h7FFF_FFFF), 8'($urandom_range(12, 40)),
                  FORM_DOUBLE);
        run_random(150, 8, 8);
        // With no steps allowed the first guess comes straight back.
        configure($urandom, 8'd0, FORM_SINGLE);
        run_random(60, 0, 0);
        configure(32'hFFFF_FFFF, 8'd255, FORM_DOUBLE);
        run_random(60, 8, 8);
        configure(32'h0000_0000, 8'd6, FORM_DOUBLE);
        run_random(60, 67, 0);

        configure($urandom_range(32'h0400_0000, 32'h7FFF_FFFF), 8'd10, FORM_SINGLE);
        @(negedge i_clk);
        cycle_limit += 2 * HOLD_CYCLES;
        pressure_go = 1'b1;
        run_random(100, 0, 0);

        repeat (20) @(negedge i_clk);
        if (err_count == 0) begin
            $display("tb_newton_square_root: clean");
        end else begin
            $display("tb_newton_square_root: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/nsr_pkg.sv
hw/rtl/nsr_mul.sv
hw/rtl/nsr_div.sv
hw/rtl/newton_square_root.sv
dv/tb_newton_square_root.sv
